[rtl/core/ipdc_pkg.sv]
// ----------------------------------------------------------------------------
// ipdc_pkg: shared types and constants for the incremental PID controller
// Register indexes, reset values, the configuration bundle and the loop
// state bundle used by the register file, the datapath and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package ipdc_pkg;

	// Field widths
	localparam int unsigned SampleW = 16;
	localparam int unsigned GainW   = 8;
	localparam int unsigned BandW   = 15;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDatW = 16;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_PROP_GAIN  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_INTEG_GAIN = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_DERIV_GAIN = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_DEAD_BAND  = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_DRIVE_MAX  = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_DRIVE_MIN  = 3'd5;

	// Register reset values
	localparam logic [GainW-1:0]   RST_PROP_GAIN  = 8'd15;
	localparam logic [GainW-1:0]   RST_INTEG_GAIN = 8'd7;
	localparam logic [GainW-1:0]   RST_DERIV_GAIN = 8'd1;
	localparam logic [BandW-1:0]   RST_DEAD_BAND  = 15'd0;
	localparam logic [SampleW-1:0] RST_DRIVE_MAX  = 16'h7FFF;
	localparam logic [SampleW-1:0] RST_DRIVE_MIN  = 16'h8000;

	// Configuration bundle
	typedef struct packed {
		logic [GainW-1:0]   prop_gain;
		logic [GainW-1:0]   integ_gain;
		logic [GainW-1:0]   deriv_gain;
		logic [BandW-1:0]   dead_band;
		logic [SampleW-1:0] drive_max;
		logic [SampleW-1:0] drive_min;
	} cfg_t;

	// Loop state carried from sample to sample
	typedef struct packed {
		logic [SampleW-1:0] err;    // previous error
		logic [SampleW-1:0] step;   // previous first difference
		logic [SampleW-1:0] acc;    // clamped accumulator (always in 16-bit range)
	} loop_state_t;

endpackage

`default_nettype wire

[rtl/core/ipdc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// ipdc_cfg_regs: configuration register file
// Six write-only registers; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module ipdc_cfg_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [ipdc_pkg::CfgIdxW-1:0]      cfg_index,
	input  wire logic [ipdc_pkg::CfgDatW-1:0]      cfg_wdata,
	output ipdc_pkg::cfg_t                         cfg
);

	ipdc_pkg::cfg_t cfg_q;

	// Register write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain  <= ipdc_pkg::RST_PROP_GAIN;
			cfg_q.integ_gain <= ipdc_pkg::RST_INTEG_GAIN;
			cfg_q.deriv_gain <= ipdc_pkg::RST_DERIV_GAIN;
			cfg_q.dead_band  <= ipdc_pkg::RST_DEAD_BAND;
			cfg_q.drive_max  <= ipdc_pkg::RST_DRIVE_MAX;
			cfg_q.drive_min  <= ipdc_pkg::RST_DRIVE_MIN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ipdc_pkg::REG_PROP_GAIN:  cfg_q.prop_gain  <= cfg_wdata[ipdc_pkg::GainW-1:0];
				ipdc_pkg::REG_INTEG_GAIN: cfg_q.integ_gain <= cfg_wdata[ipdc_pkg::GainW-1:0];
				ipdc_pkg::REG_DERIV_GAIN: cfg_q.deriv_gain <= cfg_wdata[ipdc_pkg::GainW-1:0];
				ipdc_pkg::REG_DEAD_BAND:  cfg_q.dead_band  <= cfg_wdata[ipdc_pkg::BandW-1:0];
				ipdc_pkg::REG_DRIVE_MAX:  cfg_q.drive_max  <= cfg_wdata;
				ipdc_pkg::REG_DRIVE_MIN:  cfg_q.drive_min  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[rtl/core/ipdc_datapath.sv]
// ----------------------------------------------------------------------------
// ipdc_datapath: one control update
// Error, first and second differences (16-bit wrap), deadband test,
// gain products, accumulate and clamp. Purely combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module ipdc_datapath (
	input  wire logic [ipdc_pkg::SampleW-1:0] reference,
	input  wire logic [ipdc_pkg::SampleW-1:0] feedback,
	input  ipdc_pkg::cfg_t                    cfg,
	input  ipdc_pkg::loop_state_t             state_cur,
	output ipdc_pkg::loop_state_t             state_nxt
);

	logic signed [15:0] err;
	logic signed [15:0] step;
	logic signed [15:0] step2;
	logic signed [16:0] err_x;
	logic signed [16:0] band_pos;
	logic signed [16:0] band_neg;
	logic               in_band;
	logic signed [24:0] p_prop;
	logic signed [24:0] p_integ;
	logic signed [24:0] p_deriv;
	logic signed [27:0] inc;
	logic signed [27:0] acc_sum;
	logic signed [27:0] lim_max;
	logic signed [27:0] lim_min;
	logic [15:0]        acc_new;

	// Differences, each wrapped to 16 bits
	assign err   = $signed(reference - feedback);
	assign step  = err - $signed(state_cur.err);
	assign step2 = step - $signed(state_cur.step);

	// Deadband: skip when strictly inside +/- dead_band
	assign err_x    = {err[15], err};
	assign band_pos = $signed({2'b00, cfg.dead_band});
	assign band_neg = -band_pos;
	assign in_band  = (err_x < band_pos) && (err_x > band_neg);

	// Gain products, unsigned gain times signed sample
	assign p_prop  = $signed({17'd0, cfg.prop_gain})  * $signed({{9{step[15]}}, step});
	assign p_integ = $signed({17'd0, cfg.integ_gain}) * $signed({{9{err[15]}}, err});
	assign p_deriv = $signed({17'd0, cfg.deriv_gain}) * $signed({{9{step2[15]}}, step2});

	assign inc = in_band ? 28'sd0
		: ({{3{p_prop[24]}}, p_prop} + {{3{p_integ[24]}}, p_integ}
		+ {{3{p_deriv[24]}}, p_deriv});

	assign acc_sum = {{12{state_cur.acc[15]}}, state_cur.acc} + inc;

	// Clamp: upper limit tested first
	assign lim_max = {{12{cfg.drive_max[15]}}, cfg.drive_max};
	assign lim_min = {{12{cfg.drive_min[15]}}, cfg.drive_min};

	always_comb begin
		if (acc_sum >= lim_max) begin
			acc_new = cfg.drive_max;
		end else if (acc_sum <= lim_min) begin
			acc_new = cfg.drive_min;
		end else begin
			acc_new = acc_sum[15:0];
		end
	end

	assign state_nxt.err  = err;
	assign state_nxt.step = step;
	assign state_nxt.acc  = acc_new;

endmodule

`default_nettype wire

[rtl/core/incremental_pid_deadband_clamp.sv]
// ----------------------------------------------------------------------------
// incremental_pid_deadband_clamp: velocity-form PID with deadband and clamp
// Stream in one sample per transfer, stream out one clamped drive per sample.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one sample per transfer, tdata = {feedback, reference}.
//   m_* channel: one drive value per sample, in sample order.
//   cfg_* port:  write gains, deadband and limits while the block is idle.
// Path: a taken sample is held in the input register, the update runs
//   combinationally, and the drive and its valid are registered when the output slot is free.
// Throughput: one sample per cycle while the receiver keeps up; the accumulator
//   feedback loop through the three gain multipliers and the clamp is combinational.
// Reset: error history and accumulator go to zero, registers to defaults,
//   both channels empty.
// Stall: while m_tready is low the drive holds; the input register still
//   takes one more sample, after which s_tready drops until the drive is
//   taken.
// ----------------------------------------------------------------------------
`default_nettype none

module incremental_pid_deadband_clamp (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input samples
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [15:0] reference, [31:16] feedback
	// Drive results
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [15:0] drive
	// Configuration writes
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata
);

	ipdc_pkg::cfg_t        cfg;
	ipdc_pkg::loop_state_t state_q;
	ipdc_pkg::loop_state_t state_nxt;

	logic        valid_s1;
	logic [15:0] reference_s1;
	logic [15:0] feedback_s1;
	logic        out_valid_q;
	logic        advance;

	ipdc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cfg      (cfg)
	);

	// Sample moves to the result stage when the output slot is free
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			reference_s1 <= s_tdata[15:0];
			feedback_s1  <= s_tdata[31:16];
		end
	end

	ipdc_datapath u_dp (
		.reference(reference_s1),
		.feedback (feedback_s1),
		.cfg      (cfg),
		.state_cur(state_q),
		.state_nxt(state_nxt)
	);

	// Loop state; the accumulator doubles as the output data register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = state_q.acc;

endmodule

`default_nettype wire

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: incremental PID controller with deadband and drive clamp
// Streams control samples into the block and predicts every drive value in a
// small scoreboard that keeps its own error history, accumulator and copy of
// the gain, deadband and limit registers. A directed opening covers input
// corners, both clamps, crossed limits, deadband edges and ignored register
// writes. Random phases follow, each with a new register setting. Both stream
// sides stall at random, and one phase holds off the receiver for a long
// stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import ipdc_pkg::*;

	// Indexes past the last register: writes there must be ignored
	localparam logic [CfgIdxW-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_SPARE_HI = 3'd7;

	localparam int HOLD_CYCLES = 64;

	localparam logic [SampleW-1:0] CORNER [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};

	// Predicts the clamped drive for each sample and holds the pending values
	class drive_scoreboard;
		logic [GainW-1:0]          kp, ki, kd;
		logic [BandW-1:0]          band;
		logic signed [SampleW-1:0] hi, lo;
		logic signed [SampleW-1:0] prev_err, prev_step;
		int                        acc;
		logic [SampleW-1:0]        expected_drive[$];
		int                        errors;

		function new();
			kp        = RST_PROP_GAIN;
			ki        = RST_INTEG_GAIN;
			kd        = RST_DERIV_GAIN;
			band      = RST_DEAD_BAND;
			hi        = RST_DRIVE_MAX;
			lo        = RST_DRIVE_MIN;
			prev_err  = '0;
			prev_step = '0;
			acc       = 0;
			errors    = 0;
		endfunction

		function void note_write(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] val);
			case (idx)
				REG_PROP_GAIN:  kp   = val[GainW-1:0];
				REG_INTEG_GAIN: ki   = val[GainW-1:0];
				REG_DERIV_GAIN: kd   = val[GainW-1:0];
				REG_DEAD_BAND:  band = val[BandW-1:0];
				REG_DRIVE_MAX:  hi   = val[SampleW-1:0];
				REG_DRIVE_MIN:  lo   = val[SampleW-1:0];
				default: ;
			endcase
		endfunction

		function void note_sample(logic signed [SampleW-1:0] target,
				logic signed [SampleW-1:0] measured);
			logic signed [SampleW-1:0] err, step, curve;
			int                        lim;
			// error and both differences wrap to 16 bits
			err       = target - measured;
			step      = err - prev_err;
			curve     = step - prev_step;
			prev_err  = err;
			prev_step = step;
			lim       = int'(band);
			// accumulate unless strictly inside the deadband
			if (!(int'(err) < lim && int'(err) > -lim))
				acc += int'(kp) * int'(step) + int'(ki) * int'(err) + int'(kd) * int'(curve);
			// upper limit wins when the limits are crossed
			if (acc >= int'(hi))
				acc = int'(hi);
			else if (acc <= int'(lo))
				acc = int'(lo);
			expected_drive.push_back(acc[SampleW-1:0]);
		endfunction

		function void check_drive(logic [SampleW-1:0] got);
			logic [SampleW-1:0] want;
			if (expected_drive.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: drive %0d with no sample pending", $time, $signed(got));
				return;
			end
			want = expected_drive.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("%0t: drive mismatch, expected %0d, got %0d", $time,
						$signed(want), $signed(got));
			end
		endfunction

		function int pending();
			return expected_drive.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [31:0]         s_tdata;   // [15:0] reference, [31:16] feedback
	logic                m_tvalid;
	logic                m_tready;
	logic [15:0]         m_tdata;   // [15:0] drive
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDatW-1:0]  cfg_wdata;

	bit src_stalls  = 1'b0;
	bit sink_stalls = 1'b0;
	bit hold_req    = 1'b0;

	drive_scoreboard sb = new();

	incremental_pid_deadband_clamp u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Check every drive transfer
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_drive(m_tdata);
	end

	// Receiver: random stall bursts, and a long hold-off on request
	initial begin
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Offer one sample and wait for its transfer; valid stays high afterwards
	task automatic send_sample(input logic [SampleW-1:0] target,
			input logic [SampleW-1:0] measured);
		s_tdata  <= {measured, target};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_sample(target, measured);
	endtask

	task automatic sender_gap();
		if (src_stalls && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	// Random sample: mostly errors within +/- amp, some full-range and corners
	task automatic send_random(input int unsigned amp);
		logic [SampleW-1:0] target, measured;
		int                 err;
		target = 16'($urandom);
		case ($urandom_range(0, 9))
			0: measured = 16'($urandom);
			1: begin
				target   = CORNER[2'($urandom_range(0, 3))];
				measured = CORNER[2'($urandom_range(0, 3))];
			end
			default: begin
				err      = int'($urandom_range(0, 2 * amp)) - int'(amp);
				measured = target - 16'(err);
			end
		endcase
		send_sample(target, measured);
		sender_gap();
	endtask

	// Register write; write enable stays high until end_writes
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.note_write(idx, val);
	endtask

	task automatic end_writes();
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Stop offering and let every pending drive come out
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_config(input int unsigned style, input int unsigned amp);
		logic [CfgDatW-1:0] a, b, w;
		case (style)
			0: begin
				// full-scale gains, widest limits, no deadband
				write_reg(REG_PROP_GAIN, 16'h00FF);
				write_reg(REG_INTEG_GAIN, 16'h00FF);
				write_reg(REG_DERIV_GAIN, 16'h00FF);
				write_reg(REG_DEAD_BAND, 16'h0000);
				write_reg(REG_DRIVE_MAX, 16'h7FFF);
				write_reg(REG_DRIVE_MIN, 16'h8000);
			end
			1: begin
				// zero gains with junk in the upper bits, widest deadband, extreme crossed limits
				write_reg(REG_PROP_GAIN, 16'hFF00);
				write_reg(REG_INTEG_GAIN, 16'hAA00);
				write_reg(REG_DERIV_GAIN, 16'h5500);
				write_reg(REG_DEAD_BAND, 16'hFFFF);
				write_reg(REG_DRIVE_MAX, 16'h8000);
				write_reg(REG_DRIVE_MIN, 16'h7FFF);
			end
			default: begin
				for (int r = int'(REG_PROP_GAIN); r <= int'(REG_DERIV_GAIN); r++) begin
					w = 16'($urandom);
					if ($urandom_range(0, 1) == 0)
						w[GainW-1:0] = 8'($urandom_range(0, 7));
					write_reg(CfgIdxW'(r), w);
				end
				w = 16'($urandom);
				w[BandW-1:0] = ($urandom_range(0, 3) == 0) ? '0 : 15'($urandom_range(0, amp));
				write_reg(REG_DEAD_BAND, w);
				a = 16'($urandom);
				b = 16'($urandom);
				if ($urandom_range(0, 5) == 0)
					a = 16'h7FFF;
				if ($urandom_range(0, 5) == 0)
					b = 16'h8000;
				// mostly ordered limits, sometimes left crossed
				if ($urandom_range(0, 4) != 0 && $signed(a) < $signed(b)) begin
					w = a;
					a = b;
					b = w;
				end
				write_reg(REG_DRIVE_MAX, a);
				write_reg(REG_DRIVE_MIN, b);
			end
		endcase
		write_reg(REG_SPARE_LO, 16'($urandom));
		end_writes();
	endtask

	// Stimulus
	initial begin
		int unsigned amp;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: corners of both inputs, wrapped errors
		send_sample(16'h0000, 16'h0000);
		send_sample(16'h7FFF, 16'h8000);
		send_sample(16'h8000, 16'h7FFF);
		send_sample(16'h8000, 16'h0000);
		send_sample(16'h7FFF, 16'h0000);
		send_sample(16'h0000, 16'h8000);
		send_sample(16'h7FFF, 16'h7FFF);
		send_sample(16'hFFFF, 16'hFFFF);
		wait_idle();

		// full gains push into both clamps; spare indexes change nothing
		write_reg(REG_PROP_GAIN, 16'h00FF);
		write_reg(REG_INTEG_GAIN, 16'h00FF);
		write_reg(REG_DERIV_GAIN, 16'h00FF);
		write_reg(REG_SPARE_LO, 16'hFFFF);
		write_reg(REG_SPARE_HI, 16'hFFFF);
		end_writes();
		send_sample(16'd20000, 16'h0000);
		send_sample(16'hB1E0, 16'h0000);
		send_sample(16'h0000, 16'h7FFF);
		wait_idle();

		// deadband edges: +/-99 skip, +/-100 update
		write_reg(REG_DEAD_BAND, 16'd100);
		write_reg(REG_DRIVE_MAX, 16'd1000);
		write_reg(REG_DRIVE_MIN, 16'hFC18);
		end_writes();
		send_sample(16'd99, 16'h0000);
		send_sample(16'h0000, 16'd99);
		send_sample(16'd100, 16'h0000);
		send_sample(16'hFF9C, 16'h0000);
		wait_idle();

		// widest deadband; top bit of the write data is dropped
		write_reg(REG_DEAD_BAND, 16'hFFFF);
		end_writes();
		send_sample(16'h0000, 16'h7FFF);
		send_sample(16'h7FFE, 16'h0000);
		send_sample(16'h8000, 16'h0000);
		wait_idle();

		// crossed limits: upper limit wins
		write_reg(REG_DEAD_BAND, 16'h0000);
		write_reg(REG_DRIVE_MAX, 16'hFF9C);
		write_reg(REG_DRIVE_MIN, 16'h0064);
		end_writes();
		send_sample(16'd5, 16'h0000);
		send_sample(16'hFFF0, 16'h0000);

		// random phases, one register setting each
		for (int ph = 0; ph < 8; ph++) begin
			wait_idle();
			case ($urandom_range(0, 3))
				0: amp = 32767;
				1: amp = 3000;
				2: amp = 300;
				default: amp = 30;
			endcase
			load_config((ph < 2) ? ph : 2, amp);
			src_stalls  = (ph < 7) && ($urandom_range(0, 3) != 0);
			sink_stalls = (ph < 7) && ($urandom_range(0, 3) != 0);
			if (ph == 3) begin
				// keep offering while the receiver holds off, so the input backs up
				src_stalls = 1'b0;
				hold_req   = 1'b1;
				repeat (16) send_random(amp);
				src_stalls = 1'b1;
			end
			repeat (220) send_random(amp);
		end

		// drain
		s_tvalid <= 1'b0;
		for (int n = 0; n < 20000 && sb.pending() != 0; n++)
			@(posedge clk);
		repeat (5) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	// Run limit
	initial begin
		#(20_000_000);
		$display("testbench failed");
		$finish;
	end

endmodule
